[design/srtl_pkg.sv]
// shared types and constants for the sorted record table
`default_nettype none
package srtl_pkg;
    localparam int CAPACITY_DEF = 64;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [2:0] ST_MATCH    = 3'd0;
    localparam logic [2:0] ST_NOMATCH  = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] name_w0;
        logic [63:0] name_w1;
        logic [63:0] name_w2;
        logic [47:0] name_w3;
        logic signed [15:0] birth_year;
        logic [63:0] country_w0;
        logic [15:0] country_w1;
        logic [63:0] title_w0;
        logic [63:0] title_w1;
        logic [31:0] title_w2;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_name_w0;
        logic [63:0] out_name_w1;
        logic [63:0] out_name_w2;
        logic [47:0] out_name_w3;
        logic signed [15:0] out_year;
        logic [63:0] out_country_w0;
        logic [15:0] out_country_w1;
        logic [63:0] out_title_w0;
        logic [63:0] out_title_w1;
        logic [31:0] out_title_w2;
        logic        last;
    } t_out_word;

    // one stored record: name, year, country
    typedef struct packed {
        logic [239:0] name;
        logic [15:0]  year;
        logic [79:0]  country;
    } t_rec;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture input word, normalize name
        logic rd;       // read memory at rd_addr
        logic wr_shift; // write memory at wr_addr with last read data
        logic wr_new;   // write memory at wr_addr with input record
        logic emit;     // load the result register
        logic fin;      // mark the held result as last
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic lt; // read entry less than key
        logic eq; // read entry equal to key
    } t_sts;

    // zero every byte after the first zero byte
    function automatic logic [239:0] normalize(input logic [239:0] k);
        logic [239:0] r;
        logic ended;
        r = '0;
        ended = 1'b0;
        for (int b = 29; b >= 0; b--) begin
            if (k[b*8 +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            r[b*8 +: 8] = ended ? 8'd0 : k[b*8 +: 8];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

[design/srtl_datapath.sv]
// record memory, key register, comparator and result register
`default_nettype none
module srtl_datapath #(
    parameter int CAPACITY = srtl_pkg::CAPACITY_DEF,
    parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire                  i_clk,
    input  wire srtl_pkg::t_in_word i_word,
    input  wire srtl_pkg::t_cmd  i_cmd,
    input  wire [AW-1:0]         i_rd_addr,
    input  wire [AW-1:0]         i_wr_addr,
    input  wire [2:0]            i_status,
    input  wire                  i_last,
    output srtl_pkg::t_sts       o_sts,
    output srtl_pkg::t_out_word  o_res
);
    srtl_pkg::t_rec r_mem [CAPACITY];
    srtl_pkg::t_rec r_rd;
    srtl_pkg::t_in_word r_in;
    logic [239:0] r_key;
    srtl_pkg::t_out_word r_res;
    srtl_pkg::t_out_word w_res;
    srtl_pkg::t_rec w_new;

    assign w_new = '{name: r_key, year: r_in.birth_year,
                     country: {r_in.country_w0, r_in.country_w1}};

    // input capture and key normalize
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in  <= i_word;
            r_key <= srtl_pkg::normalize({i_word.name_w0, i_word.name_w1,
                                          i_word.name_w2, i_word.name_w3});
        end
    end

    // record memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_shift) begin
            r_mem[i_wr_addr] <= r_rd;
        end else if (i_cmd.wr_new) begin
            r_mem[i_wr_addr] <= w_new;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_sts.lt = r_rd.name < r_key;
    assign o_sts.eq = r_rd.name == r_key;

    // next result word
    always_comb begin
        w_res = '0;
        w_res.status = i_status;
        w_res.last   = i_last;
        if (i_status == srtl_pkg::ST_MATCH) begin
            {w_res.out_name_w0, w_res.out_name_w1, w_res.out_name_w2,
             w_res.out_name_w3} = r_rd.name;
            w_res.out_year = r_rd.year;
            {w_res.out_country_w0, w_res.out_country_w1} = r_rd.country;
        end else if (i_status == srtl_pkg::ST_NOMATCH) begin
            {w_res.out_name_w0, w_res.out_name_w1, w_res.out_name_w2,
             w_res.out_name_w3} = r_key;
        end
        if (i_status == srtl_pkg::ST_MATCH || i_status == srtl_pkg::ST_NOMATCH)
        begin
            w_res.out_title_w0 = r_in.title_w0;
            w_res.out_title_w1 = r_in.title_w1;
            w_res.out_title_w2 = r_in.title_w2;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res <= w_res;
        end else if (i_cmd.fin) begin
            r_res.last <= 1'b1;
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

[design/srtl_ctrl.sv]
// controller: binary search, insert shift and match scan sequencing
`default_nettype none
module srtl_ctrl #(
    parameter int CAPACITY = srtl_pkg::CAPACITY_DEF,
    parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW = $clog2(CAPACITY + 1)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire [1:0]           i_op,
    input  wire srtl_pkg::t_sts i_sts,
    output srtl_pkg::t_cmd      o_cmd,
    output logic [AW-1:0]       o_rd_addr,
    output logic [AW-1:0]       o_wr_addr,
    output logic [2:0]          o_status,
    output logic                o_last,
    output logic                o_busy,
    output logic                o_valid,
    output logic [CW-1:0]       o_count
);
    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SWAIT, S_SCMP, S_SHRD, S_SHWR, S_INS,
        S_QRD, S_QWAIT, S_QCMP, S_QCAP, S_QEMIT, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_cnt, n_cnt, r_idx, n_idx;
    logic [1:0] r_op, n_op;
    logic r_any, n_any;
    logic r_valid, n_valid;
    srtl_pkg::t_cmd n_cmd;
    logic [2:0] n_status;
    logic n_last;
    logic [CW-1:0] w_mid;

    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        n_state = r_state; n_lo = r_lo; n_hi = r_hi; n_cnt = r_cnt;
        n_idx = r_idx; n_op = r_op; n_any = r_any; n_valid = 1'b0;
        n_cmd = '0; n_status = srtl_pkg::ST_MATCH; n_last = 1'b1;
        o_rd_addr = '0; o_wr_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd.load = 1'b1;
                    n_op = i_op;
                    n_lo = '0; n_hi = r_cnt; n_any = 1'b0;
                    if (i_op == srtl_pkg::OP_CLEAR) begin
                        n_cnt = '0; n_cmd.emit = 1'b1; n_valid = 1'b1;
                        n_status = srtl_pkg::ST_CLEARED;
                        n_state = S_DONE;
                    end else if (i_op == srtl_pkg::OP_INSERT) begin
                        if (r_cnt >= CW'(CAPACITY)) begin
                            n_cmd.emit = 1'b1; n_valid = 1'b1;
                            n_status = srtl_pkg::ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SRCH;
                        end
                    end else if (i_op == srtl_pkg::OP_QUERY) begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_cmd.rd = 1'b1; o_rd_addr = w_mid[AW-1:0];
                    n_state = S_SWAIT;
                end else if (r_op == srtl_pkg::OP_INSERT) begin
                    n_idx = r_cnt; n_state = S_SHRD;
                end else begin
                    n_idx = r_lo; n_state = S_QRD;
                end
            end
            S_SWAIT: n_state = S_SCMP;
            S_SCMP: begin
                if (i_sts.lt || (r_op == srtl_pkg::OP_INSERT && i_sts.eq)) begin
                    n_lo = w_mid + CW'(1);
                end else begin
                    n_hi = w_mid;
                end
                n_state = S_SRCH;
            end
            S_SHRD: begin
                if (r_idx > r_lo) begin
                    n_cmd.rd = 1'b1;
                    o_rd_addr = AW'(r_idx - CW'(1));
                    n_state = S_SHWR;
                end else begin
                    n_state = S_INS;
                end
            end
            S_SHWR: begin
                n_cmd.wr_shift = 1'b1; o_wr_addr = r_idx[AW-1:0];
                n_idx = r_idx - CW'(1);
                n_state = S_SHRD;
            end
            S_INS: begin
                n_cmd.wr_new = 1'b1; o_wr_addr = r_lo[AW-1:0];
                n_cnt = r_cnt + CW'(1);
                n_cmd.emit = 1'b1; n_valid = 1'b1;
                n_status = srtl_pkg::ST_INSERTED;
                n_state = S_DONE;
            end
            S_QRD: begin
                if (r_idx < r_cnt) begin
                    n_cmd.rd = 1'b1; o_rd_addr = r_idx[AW-1:0];
                    n_state = S_QWAIT;
                end else begin
                    n_state = S_QEMIT;
                end
            end
            S_QWAIT: n_state = S_QCMP;
            S_QCMP: begin
                if (i_sts.eq) begin
                    // another match: the held one is shown, not last
                    n_valid = r_any;
                    n_state = S_QCAP;
                end else begin
                    n_state = S_QEMIT;
                end
            end
            S_QCAP: begin
                // hold the match in the result register until the next compare
                n_cmd.emit = 1'b1;
                n_status = srtl_pkg::ST_MATCH;
                n_last = 1'b0;
                n_any = 1'b1;
                n_idx = r_idx + CW'(1);
                n_state = S_QRD;
            end
            S_QEMIT: begin
                if (r_any) begin
                    // scan ended: show the held match as last
                    n_cmd.fin = 1'b1; n_valid = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_cmd.emit = 1'b1; n_valid = 1'b1;
                    n_status = srtl_pkg::ST_NOMATCH;
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_valid <= 1'b0;
            r_lo <= '0; r_hi <= '0; r_idx <= '0; r_op <= '0; r_any <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_valid <= n_valid;
            r_lo <= n_lo; r_hi <= n_hi; r_idx <= n_idx; r_op <= n_op;
            r_any <= n_any;
        end
    end

    assign o_cmd = n_cmd;
    assign o_status = n_status;
    assign o_last = n_last;
    assign o_busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_count = r_cnt;
endmodule
`default_nettype wire

[design/sorted_record_table_lookup.sv]
// sorted record table: top level joining controller and datapath
// clear and full insert: result in the cycle after accept, busy only in S_DONE
// search step: read the middle entry, wait, compare; at most log2(n)+1 steps
// insert shifts later entries up, then writes; query scans equal entries; one read port
// one item at a time; busy high after accept until its last result is shown
// synchronous active-low reset empties the table; results cannot be stalled
`default_nettype none
module sorted_record_table_lookup #(
    parameter int CAPACITY = srtl_pkg::CAPACITY_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    input  wire srtl_pkg::t_in_word  i_word,
    output logic                     busy,
    output logic                     o_strobe,
    output srtl_pkg::t_out_word      o_word
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    srtl_pkg::t_cmd w_cmd;
    srtl_pkg::t_sts w_sts;
    logic [AW-1:0] w_rd, w_wr;
    logic [2:0] w_status;
    logic w_last, w_busy, w_valid;
    logic [CW-1:0] w_count;

    srtl_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_op(i_word.op),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_rd_addr(w_rd), .o_wr_addr(w_wr),
        .o_status(w_status), .o_last(w_last), .o_busy(w_busy),
        .o_valid(w_valid), .o_count(w_count)
    );

    srtl_datapath #(.CAPACITY(CAPACITY), .AW(AW)) u_dp (
        .i_clk(i_clk), .i_word(i_word), .i_cmd(w_cmd), .i_rd_addr(w_rd),
        .i_wr_addr(w_wr), .i_status(w_status), .i_last(w_last),
        .o_sts(w_sts), .o_res(o_word)
    );

    assign busy = w_busy;
    assign o_strobe = w_valid;

    // table never overfills
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(CAPACITY)) else $error("entry count overflow");
    // a result only appears while the item is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy) else $error("result outside an item");
    // the block is free in the cycle after a last result
    a_last_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.last) |=> !busy) else $error("stuck after last");
endmodule
`default_nettype wire
